// ----- rtl/tiled_32x32_to_raster_plane_core_assert.svh -----
// Assertion macros shared by the detiler modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef TILED_32X32_TO_RASTER_PLANE_CORE_ASSERT_SVH
`define TILED_32X32_TO_RASTER_PLANE_CORE_ASSERT_SVH

// Same-cycle implication.
`define TTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ttr_pkg.sv -----
// ----------------------------------------------------------------------------
// ttr_pkg: shared definitions of the tiled-to-raster detiler
// Register map codes, frame limits and the position record passed from the
// address unit to the output stage.
// ----------------------------------------------------------------------------
package ttr_pkg;

    // Width of the frame size registers.
    localparam int CFG_W = 13;

    // Largest frame size that is honored; larger register values are clipped.
    localparam logic [CFG_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [CFG_W-1:0] MAX_HEIGHT = 13'd4096;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PLANE_MODE   = 2'd2;

    // Reset values of the registers.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1088;

    // Plane modes.
    localparam logic MODE_LUMA   = 1'b0;
    localparam logic MODE_CHROMA = 1'b1;

    // Number of byte lanes; each lane produces one byte of each output half.
    localparam int LANES = 8;

    // Position of one chunk, handed from the address unit to the output stage.
    typedef struct packed {
        logic [12:0] row;
        logic [13:0] col;
        logic [12:0] width;
        logic        in_frame;
        logic        last;
    } ttr_pos_t;

endpackage

// ----- rtl/ttr_addr.sv -----
// ----------------------------------------------------------------------------
// ttr_addr: tile walk counters and chunk position
// Tracks tile row, column pair, line within the tile and half of the pair,
// and registers the raster row, column and frame test of each chunk.
// ----------------------------------------------------------------------------
`include "tiled_32x32_to_raster_plane_core_assert.svh"

module ttr_addr (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [ttr_pkg::CFG_W-1:0] frame_width,
    input  logic [ttr_pkg::CFG_W-1:0] frame_height,
    input  logic                     plane_mode,
    output ttr_pkg::ttr_pos_t        pos
);
    import ttr_pkg::*;

    logic [7:0]       tile_row_reg, tile_row_next;
    logic [8:0]       column_pair_reg, column_pair_next;
    logic [4:0]       line_reg, line_next;
    logic             second_half_reg, second_half_next;
    logic [CFG_W-1:0] w_clip, h_clip;
    logic [8:0]       pairs_raw, pairs;
    logic [7:0]       rows_raw, rows;
    logic             line_wrap, pair_wrap, row_wrap;
    logic [12:0]      row_pos;
    logic [13:0]      col_pos;
    logic             in_frame, last_next;
    ttr_pos_t         pos_reg;

    // Clip the frame size and derive the tile grid.
    always_comb
    begin
        w_clip    = (frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width;
        h_clip    = (frame_height > MAX_HEIGHT) ? MAX_HEIGHT : frame_height;
        pairs_raw = (plane_mode == MODE_CHROMA) ? 9'((w_clip + 13'd15) >> 4)
                                                : 9'((w_clip + 13'd31) >> 5);
        pairs     = (pairs_raw == 9'd0) ? 9'd1 : pairs_raw;
        rows_raw  = 8'((h_clip + 13'd31) >> 5);
        rows      = (rows_raw == 8'd0) ? 8'd1 : rows_raw;
    end

    // Raster position of the current chunk start and the frame test.
    always_comb
    begin
        row_pos = {tile_row_reg, line_reg};
        if (plane_mode == MODE_CHROMA)
        begin
            col_pos = {1'b0, column_pair_reg, second_half_reg, 3'b000};
        end
        else
        begin
            col_pos = {column_pair_reg, second_half_reg, 4'b0000};
        end
        in_frame = (row_pos < h_clip) && (col_pos < {1'b0, w_clip});
    end

    // Counter advance: half, then line, then column pair, then tile row.
    always_comb
    begin
        line_wrap        = (line_reg == 5'd31);
        pair_wrap        = (({1'b0, column_pair_reg} + 10'd1) >= {1'b0, pairs});
        row_wrap         = (({1'b0, tile_row_reg} + 9'd1) >= {1'b0, rows});
        last_next        = second_half_reg && line_wrap && pair_wrap && row_wrap;
        second_half_next = second_half_reg;
        line_next        = line_reg;
        column_pair_next = column_pair_reg;
        tile_row_next    = tile_row_reg;
        if (load)
        begin
            second_half_next = ~second_half_reg;
            if (second_half_reg)
            begin
                line_next = line_reg + 5'd1;
                if (line_wrap)
                begin
                    column_pair_next = pair_wrap ? 9'd0 : column_pair_reg + 9'd1;
                    if (pair_wrap)
                    begin
                        tile_row_next = row_wrap ? 8'd0 : tile_row_reg + 8'd1;
                    end
                end
            end
        end
    end

    // Counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_row_reg    <= '0;
            column_pair_reg <= '0;
            line_reg        <= '0;
            second_half_reg <= 1'b0;
        end
        else
        begin
            tile_row_reg    <= tile_row_next;
            column_pair_reg <= column_pair_next;
            line_reg        <= line_next;
            second_half_reg <= second_half_next;
        end
    end

    // Position record of the accepted chunk.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg.row      <= row_pos;
            pos_reg.col      <= col_pos;
            pos_reg.width    <= w_clip;
            pos_reg.in_frame <= in_frame;
            pos_reg.last     <= last_next;
        end
    end

    assign pos = pos_reg;

    // The plane ends only on a second-half chunk, and the walk restarts at zero.
    `TTR_ASSERT_NEXT(a_last_restarts, load && last_next, (tile_row_reg == 8'd0) && (column_pair_reg == 9'd0) && (line_reg == 5'd0) && !second_half_reg, "counters did not restart after the last chunk")
    `TTR_ASSERT_NOW(a_last_on_second_half, load && last_next, second_half_reg && line_wrap, "last chunk flagged off the end of a pair")

endmodule

// ----- rtl/ttr_lane.sv -----
// ----------------------------------------------------------------------------
// ttr_lane: one byte lane of the chunk data path
// Picks the output bytes of one lane: in luma mode the bytes at the lane
// position of each chunk half, in chroma mode one Cb and one Cr byte.
// ----------------------------------------------------------------------------
module ttr_lane (
    input  logic       clk,
    input  logic       load,
    input  logic       plane_mode,
    input  logic [7:0] luma_lo,
    input  logic [7:0] luma_hi,
    input  logic [7:0] chroma_cb,
    input  logic [7:0] chroma_cr,
    output logic [7:0] lo_byte,
    output logic [7:0] hi_byte
);
    import ttr_pkg::*;

    logic [7:0] lo_reg, hi_reg;
    logic [7:0] lo_next, hi_next;

    // Byte selection by plane mode.
    always_comb
    begin
        if (plane_mode == MODE_CHROMA)
        begin
            lo_next = chroma_cb;
            hi_next = chroma_cr;
        end
        else
        begin
            lo_next = luma_lo;
            hi_next = luma_hi;
        end
    end

    // Lane data register, loaded with each accepted chunk.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo_byte = lo_reg;
    assign hi_byte = hi_reg;

endmodule

// ----- rtl/tiled_32x32_to_raster_plane_core.sv -----
// ----------------------------------------------------------------------------
// tiled_32x32_to_raster_plane_core: tiled-to-raster plane detiler
// Takes 16-byte chunks of a 32-row tiled plane and gives for each the raster
// offset, the luma bytes or split Cb/Cr bytes, a write enable and a flag on
// the final chunk of the plane.
//
//   Channel   Handshake                   Payload
//   chunk     chunk_valid / chunk_stall   chunk_lo, chunk_hi
//   result    result_valid / result_stall dest_offset, data_lo, data_hi,
//                                         write_enable, last_chunk
//   config    APB write and read          paddr, pwdata, prdata
//
// One chunk is accepted per cycle while chunk_stall is low. A taken chunk
// loads the lane and address stage, then the output register through the
// offset multiply when the stage passes it on; its result transfers when
// result_stall is low. The stage and output registers each hold one transfer,
// so a chunk is still taken while one result waits. Reset clears the tile
// counters and loads the default frame of 1920 by 1088 luma.
// ----------------------------------------------------------------------------
`include "tiled_32x32_to_raster_plane_core_assert.svh"

module tiled_32x32_to_raster_plane_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        chunk_valid,
    output logic        chunk_stall,
    input  logic [63:0] chunk_lo,
    input  logic [63:0] chunk_hi,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [23:0] dest_offset,
    output logic [63:0] data_lo,
    output logic [63:0] data_hi,
    output logic        write_enable,
    output logic        last_chunk
);
    import ttr_pkg::*;

    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic             plane_mode_reg;
    logic             cfg_write;
    logic             chunk_take, out_ready, stage_ready, stage_move;
    logic             stage_valid_reg, stage_valid_next;
    logic             result_valid_reg, result_valid_next;
    logic [127:0]     chunk_all;
    logic [LANES*8-1:0] lane_lo, lane_hi;
    ttr_pos_t         pos;
    logic [25:0]      offset_sum;
    logic [23:0]      dest_offset_reg;
    logic [63:0]      data_lo_reg, data_hi_reg;
    logic             write_enable_reg, last_chunk_reg;

    // Configuration registers.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            plane_mode_reg   <= MODE_LUMA;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                REG_PLANE_MODE:   plane_mode_reg   <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_reg};
            REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_reg};
            REG_PLANE_MODE:   prdata = {31'd0, plane_mode_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Handshake: each stage fills when it is empty or passes its transfer on.
    always_comb
    begin
        out_ready        = !result_valid_reg || !result_stall;
        stage_ready      = !stage_valid_reg || out_ready;
        chunk_take       = chunk_valid && stage_ready;
        stage_move       = stage_valid_reg && out_ready;
        stage_valid_next = chunk_take ? 1'b1 : (stage_move ? 1'b0 : stage_valid_reg);
        result_valid_next = stage_move ? 1'b1 : (out_ready ? 1'b0 : result_valid_reg);
    end

    assign chunk_stall = !stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Address unit: tile walk and chunk position.
    ttr_addr u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (chunk_take),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .plane_mode   (plane_mode_reg),
        .pos          (pos)
    );

    // Byte lanes; lane k serves output byte k of both halves.
    assign chunk_all = {chunk_hi, chunk_lo};

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        ttr_lane u_lane (
            .clk        (clk),
            .load       (chunk_take),
            .plane_mode (plane_mode_reg),
            .luma_lo    (chunk_lo[8*k +: 8]),
            .luma_hi    (chunk_hi[8*k +: 8]),
            .chroma_cb  (chunk_all[16*k +: 8]),
            .chroma_cr  (chunk_all[16*k+8 +: 8]),
            .lo_byte    (lane_lo[8*k +: 8]),
            .hi_byte    (lane_hi[8*k +: 8])
        );
    end

    // Raster offset: row times stride plus column.
    assign offset_sum = ({13'd0, pos.row} * {13'd0, pos.width}) + {12'd0, pos.col};

    // Output register merges the lanes with the offset.
    always_ff @(posedge clk)
    begin
        if (stage_move)
        begin
            dest_offset_reg  <= pos.in_frame ? offset_sum[23:0] : 24'd0;
            data_lo_reg      <= lane_lo;
            data_hi_reg      <= lane_hi;
            write_enable_reg <= pos.in_frame;
            last_chunk_reg   <= pos.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign dest_offset  = dest_offset_reg;
    assign data_lo      = data_lo_reg;
    assign data_hi      = data_hi_reg;
    assign write_enable = write_enable_reg;
    assign last_chunk   = last_chunk_reg;

    // A skipped chunk carries a zero offset.
    `TTR_ASSERT_NOW(a_skip_zero_offset, result_valid_reg && !write_enable_reg, dest_offset_reg == 24'd0, "skipped chunk with nonzero offset")
    // With both stages full and the output held, no chunk is taken.
    `TTR_ASSERT_NOW(a_full_stalls, stage_valid_reg && result_valid_reg && result_stall, chunk_stall, "chunk taken with the pipeline full")
    // An accepted chunk always lands in the stage register.
    `TTR_ASSERT_NEXT(a_take_fills, chunk_valid && !chunk_stall, stage_valid_reg, "accepted chunk lost")
    // A held result is not replaced.
    `TTR_ASSERT_NEXT(a_hold_result, result_valid_reg && result_stall, result_valid_reg && $stable(dest_offset_reg) && $stable(last_chunk_reg), "held result changed")

endmodule
